@@ hw/rtl/modular_exponent_inverse_divide_top_defines.svh @@
// assertion macros for the modular exponent block
`ifndef MODULAR_EXPONENT_INVERSE_DIVIDE_TOP_DEFINES_SVH
`define MODULAR_EXPONENT_INVERSE_DIVIDE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MEID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MEID_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MEID_ASSERT(label, clk, rst_n, prop, msg)
`define MEID_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/meid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meid_pkg
// types and constants for the modular exponent block
// ----------------------------------------------------------------------------
package meid_pkg;
    localparam int unsigned EXP_BITS_DEF = 64;
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

    typedef enum logic [1:0] {
        OP_POWER   = 2'd0,
        OP_INVERSE = 2'd1,
        OP_DIVIDE  = 2'd2,
        OP_INVALID = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_SQ_MUL,
        ST_SQ_RED,
        ST_BM_MUL,
        ST_BM_RED,
        ST_DV_MUL,
        ST_DV_RED,
        ST_DONE
    } state_t;
endpackage

@@ hw/rtl/modular_exponent_inverse_divide_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponent_inverse_divide_top
// modular power, fermat inverse and modular divide on a shared multiplier
// ----------------------------------------------------------------------------
// One item at a time: in_ready is high only while the block is idle. A single
// 32x32 multiplier feeds a bit-serial reducer, and each multiply-and-reduce
// step waits for the reducer to finish. Power reduces the base, then walks all
// EXP_BITS exponent bits from the top, one square per bit and one multiply per
// set bit; inverse walks the 32 bits of m-2 the same way; divide also reduces
// the dividend and adds one last product. Errors skip the arithmetic and go
// straight to the final state. A result left waiting on out_ready holds the
// next item in its final state, and the input stalls until that item is out.
`include "modular_exponent_inverse_divide_top_defines.svh"
module modular_exponent_inverse_divide_top
    import meid_pkg::*;
#(
    parameter int unsigned EXP_BITS = EXP_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [62:0] operand_a,
    input  logic [62:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result,
    output logic        error
);
    localparam int unsigned EW = (EXP_BITS > 32) ? EXP_BITS : 32;
    localparam int unsigned CW = $clog2(EW + 1);

    state_t state_reg, state_next;
    logic [31:0]   mod_reg;
    logic [1:0]    op_reg, op_next;
    logic [62:0]   a_in_reg, a_in_next;
    logic [EW-1:0] exp_reg, exp_next;
    logic [CW-1:0] bit_reg, bit_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   base_reg, base_next;
    logic [31:0]   ar_reg, ar_next;
    logic [63:0]   prod;
    logic [63:0]   b_wide;
    logic [31:0]   res_reg, res_next;
    logic          err_reg, err_next;
    logic          out_valid_reg, out_valid_next;
    logic          red_start, red_busy;
    logic [63:0]   red_in;
    logic [31:0]   red_rem;
    logic [31:0]   mul_x, mul_y;
    logic          bad_in, bad_op;

    meid_reducer u_red (
        .clk(clk), .rst_n(rst_n), .start(red_start), .dividend(red_in),
        .modulus(mod_reg), .busy(red_busy), .remainder(red_rem)
    );

    assign prod   = mul_x * mul_y;
    assign b_wide = {1'b0, operand_b};

    // zero modulus, invalid opcode, or inverse/divide with modulus below 2
    assign bad_in = (mod_reg == 32'd0) || (opcode_t'(opcode) == OP_INVALID)
                    || (opcode_t'(opcode) != OP_POWER && mod_reg < 32'd2);
    assign bad_op = (mod_reg == 32'd0) || (opcode_t'(op_reg) == OP_INVALID)
                    || (opcode_t'(op_reg) != OP_POWER && mod_reg < 32'd2);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_in_next      = a_in_reg;
        exp_next       = exp_reg;
        bit_next       = bit_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        ar_next        = ar_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        red_start      = 1'b0;
        red_in         = prod;
        mul_x          = acc_reg;
        mul_y          = acc_reg;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next   = opcode;
                    a_in_next = operand_a;
                    acc_next  = (mod_reg == 32'd1) ? 32'd0 : 32'd1;
                    if (bad_in)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // exponent is left-aligned so its top bit is always exp_reg msb
                        if (opcode_t'(opcode) == OP_POWER)
                        begin
                            exp_next = EW'(b_wide[EXP_BITS-1:0]) << (EW - EXP_BITS);
                            bit_next = CW'(EXP_BITS);
                            red_in   = {1'b0, operand_a};
                        end
                        else
                        begin
                            exp_next = EW'(mod_reg - 32'd2) << (EW - 32);
                            bit_next = CW'(32);
                            red_in   = {1'b0, operand_b};
                        end
                        red_start  = 1'b1;
                        state_next = ST_RED_B;
                    end
                end
            end
            ST_RED_B:
            begin
                // base reduction
                if (!red_busy)
                begin
                    base_next = red_rem;
                    if (opcode_t'(op_reg) == OP_DIVIDE)
                    begin
                        red_start  = 1'b1;
                        red_in     = {1'b0, a_in_reg};
                        state_next = ST_RED_A;
                    end
                    else
                    begin
                        state_next = ST_SQ_MUL;
                    end
                end
            end
            ST_RED_A:
            begin
                if (!red_busy)
                begin
                    ar_next    = red_rem;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL:
            begin
                red_start  = 1'b1;
                state_next = ST_SQ_RED;
            end
            ST_SQ_RED:
            begin
                if (!red_busy)
                begin
                    acc_next = red_rem;
                    if (exp_reg[EW-1])
                    begin
                        state_next = ST_BM_MUL;
                    end
                    else
                    begin
                        exp_next   = exp_reg << 1;
                        bit_next   = bit_reg - CW'(1);
                        state_next = (bit_reg == CW'(1)) ? ST_DV_MUL : ST_SQ_MUL;
                    end
                end
            end
            ST_BM_MUL:
            begin
                mul_y      = base_reg;
                red_start  = 1'b1;
                state_next = ST_BM_RED;
            end
            ST_BM_RED:
            begin
                if (!red_busy)
                begin
                    acc_next   = red_rem;
                    exp_next   = exp_reg << 1;
                    bit_next   = bit_reg - CW'(1);
                    state_next = (bit_reg == CW'(1)) ? ST_DV_MUL : ST_SQ_MUL;
                end
            end
            ST_DV_MUL:
            begin
                if (opcode_t'(op_reg) == OP_DIVIDE)
                begin
                    mul_x      = ar_reg;
                    mul_y      = acc_reg;
                    red_start  = 1'b1;
                    state_next = ST_DV_RED;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DV_RED:
            begin
                if (!red_busy)
                begin
                    acc_next   = red_rem;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_next       = bad_op ? 32'd0 : acc_reg;
                    err_next       = bad_op;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                mod_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_in_reg <= a_in_next;
        exp_reg  <= exp_next;
        bit_reg  <= bit_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        ar_reg   <= ar_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;
    assign error     = err_reg;

    `MEID_ASSERT(a_err_zero, clk, rst_n, out_valid && error |-> result == 32'd0, "error with result")
    `MEID_ASSERT(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE |-> !in_ready, "ready while busy")
    `MEID_ASSERT(a_res_lt_mod, clk, rst_n, out_valid && !error |-> result < mod_reg, "not reduced")
    `MEID_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "item dropped")
endmodule

@@ hw/rtl/meid_reducer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meid_reducer
// bit-serial remainder of a 64-bit value by a 32-bit modulus, one bit a cycle
// ----------------------------------------------------------------------------
module meid_reducer
    import meid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] modulus,
    output logic        busy,
    output logic [31:0] remainder
);
    logic [63:0] shift_reg, shift_next;
    logic [32:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] trial;

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        trial      = {rem_reg[31:0], shift_reg[63]};
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            shift_next = {shift_reg[62:0], 1'b0};
            rem_next   = (trial >= {1'b0, modulus}) ? trial - {1'b0, modulus} : trial;
            cnt_next   = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    // busy from the cycle after start until the remainder is ready
    assign busy      = (cnt_reg != 7'd0);
    assign remainder = rem_reg[31:0];
endmodule
